// ===== hw/rtl/quadgram_fitness_scorer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quadgram fitness scorer
// Every use expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef QUADGRAM_FITNESS_SCORER_MACROS_SVH
`define QUADGRAM_FITNESS_SCORER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define QFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define QFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/qfs_pkg.sv =====
// ----------------------------------------------------------------------------
// qfs_pkg
// Shared widths, codes, character constants and the item that travels
// through the row of match cells.
// ----------------------------------------------------------------------------
`default_nettype none

package qfs_pkg;

  // Default sizes of the design.
  localparam int unsigned TableDepthDef = 128;
  localparam int unsigned CountBitsDef  = 16;

  // Field widths of the channels.
  localparam int unsigned OpW    = 2;
  localparam int unsigned IndexW = 7;
  localparam int unsigned GramW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FitW   = 20;
  localparam int unsigned OutCntW = 16;

  // Operation codes of an input item.
  typedef enum logic [OpW-1:0] {
    OP_LOAD  = 2'd0,
    OP_TEXT  = 2'd1,
    OP_EMPTY = 2'd2,
    OP_NONE  = 2'd3
  } qfs_op_e;

  // Character codes.
  localparam logic [ByteW-1:0] ChUnmapped = 8'h5F;  // '_'
  localparam logic [ByteW-1:0] ChLowA = 8'h61;
  localparam logic [ByteW-1:0] ChLowE = 8'h65;
  localparam logic [ByteW-1:0] ChLowI = 8'h69;
  localparam logic [ByteW-1:0] ChLowO = 8'h6F;
  localparam logic [ByteW-1:0] ChLowU = 8'h75;
  localparam logic [ByteW-1:0] ChUpA  = 8'h41;
  localparam logic [ByteW-1:0] ChUpE  = 8'h45;
  localparam logic [ByteW-1:0] ChUpI  = 8'h49;
  localparam logic [ByteW-1:0] ChUpO  = 8'h4F;
  localparam logic [ByteW-1:0] ChUpU  = 8'h55;

  // One slot of the cell row: either a table load or a text window.
  typedef struct packed {
    logic              vld;      // slot holds an item
    logic              load;     // table load rather than text
    logic [IndexW-1:0] index;    // table slot of a load
    logic              keep;     // valid flag of a load
    logic [GramW-1:0]  data;     // gram of a load, window of text
    logic              chk;      // window is complete and may score
    logic              hit;      // some cell so far matched the window
    logic              unm_inc;  // count one unmapped byte
    logic              vwl_inc;  // count one vowelless word
    logic              emit;     // passage closes: send a result
  } qfs_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/qfs_if.sv =====
// ----------------------------------------------------------------------------
// qfs_in_if / qfs_out_if
// Valid/ready channels of the scorer: text and table loads in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface qfs_in_if;
  import qfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [OpW-1:0]    operation;
  logic [IndexW-1:0] table_index;
  logic [GramW-1:0]  table_gram;
  logic              table_keep;
  logic [ByteW-1:0]  text_byte;
  logic              word_end;
  logic              passage_end;

  modport source (
    output valid, operation, table_index, table_gram, table_keep, text_byte,
           word_end, passage_end,
    input  ready
  );
  modport sink (
    input  valid, operation, table_index, table_gram, table_keep, text_byte,
           word_end, passage_end,
    output ready
  );
endinterface

interface qfs_out_if;
  import qfs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FitW-1:0]    fitness;
  logic        [OutCntW-1:0] quad_hits;
  logic        [OutCntW-1:0] vowelless_words;
  logic        [OutCntW-1:0] unmapped_bytes;

  modport source (
    output valid, fitness, quad_hits, vowelless_words, unmapped_bytes,
    input  ready
  );
  modport sink (
    input  valid, fitness, quad_hits, vowelless_words, unmapped_bytes,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/quadgram_fitness_scorer.sv =====
// ----------------------------------------------------------------------------
// quadgram_fitness_scorer
// Scores a trial decryption against a table of known four-letter grams.
// The in_i channel takes table loads, text bytes and empty words; each
// item moves through a row of TABLE_DEPTH match cells, one cell per cycle
// while the row advances, and each cell holds one table slot. Loads travel
// the same row, so every window is scored against exactly the loads that
// came before it. One input item is taken per cycle while the row
// advances. A result is valid on out_o once the item that closes the
// passage has passed the last cell: the first cell registers the item at
// its accepting edge, and the output register follows the last cell.
// While out_o is stalled the row keeps moving; it halts, and in_i.ready
// drops, only when a second result reaches the end of the row.
// Reset clears all table slots, the word state and the counters; no
// clearing pass is needed and items are taken from the first cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module quadgram_fitness_scorer #(
  parameter int unsigned TABLE_DEPTH = qfs_pkg::TableDepthDef,
  parameter int unsigned COUNT_BITS  = qfs_pkg::CountBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  qfs_in_if.sink   in_i,
  qfs_out_if.source out_o
);
  import qfs_pkg::*;
  `include "quadgram_fitness_scorer_macros.svh"

  qfs_item_t       chain [TABLE_DEPTH+1];
  qfs_item_t       tail_item;
  logic            chain_en;
  logic            take;
  logic [FitW-1:0] fit_chk;

  assign in_i.ready = chain_en;
  assign take       = in_i.valid && chain_en;

  // Word tracking and item build.
  qfs_word_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .operation_i   (in_i.operation),
    .table_index_i (in_i.table_index),
    .table_gram_i  (in_i.table_gram),
    .table_keep_i  (in_i.table_keep),
    .text_byte_i   (in_i.text_byte),
    .word_end_i    (in_i.word_end),
    .passage_end_i (in_i.passage_end),
    .item_o        (chain[0])
  );

  // Row of match cells, one per table slot.
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    qfs_match_cell #(
      .CELL_ID (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (chain_en),
      .item_i (chain[k]),
      .item_o (chain[k+1])
    );
  end

  assign tail_item = chain[TABLE_DEPTH];

  // Counters and result register.
  qfs_tally #(
    .COUNT_BITS (COUNT_BITS)
  ) u_tally (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tail_i (tail_item),
    .adv_o  (chain_en),
    .out_o  (out_o)
  );

  // Fitness recomputed from the sent counts.
  assign fit_chk = (FitW'(out_o.quad_hits) << 2) - (FitW'(out_o.vowelless_words) << 2) -
                   (FitW'(out_o.unmapped_bytes) + (FitW'(out_o.unmapped_bytes) << 1));

  `QFS_ASSERT(a_halt_on_second_result,
    (tail_item.vld && tail_item.emit && out_o.valid && !out_o.ready) |-> !in_i.ready,
    "row advanced while a result was blocked")
  `QFS_ASSERT(a_result_from_tail,
    $rose(out_o.valid) |-> $past(tail_item.vld && tail_item.emit && chain_en),
    "result appeared without a closing item")
  `QFS_ASSERT(a_fitness_sum,
    out_o.valid |-> ((COUNT_BITS > 16) || (out_o.fitness == fit_chk)),
    "fitness does not match the counts")
  `QFS_ASSERT_NEXT(a_result_once,
    out_o.valid && out_o.ready && !(tail_item.vld && tail_item.emit && chain_en),
    !out_o.valid,
    "result repeated after it was taken")

endmodule

`default_nettype wire

// ===== hw/rtl/qfs_word_front.sv =====
// ----------------------------------------------------------------------------
// qfs_word_front
// Tracks the current word and turns each accepted input but OP_NONE into one
// item for the cell row: a load, or a text window with its counting flags.
// ----------------------------------------------------------------------------
`default_nettype none

module qfs_word_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic [qfs_pkg::OpW-1:0]    operation_i,
  input  logic [qfs_pkg::IndexW-1:0] table_index_i,
  input  logic [qfs_pkg::GramW-1:0]  table_gram_i,
  input  logic                       table_keep_i,
  input  logic [qfs_pkg::ByteW-1:0]  text_byte_i,
  input  logic                       word_end_i,
  input  logic                       passage_end_i,
  output qfs_pkg::qfs_item_t         item_o
);
  import qfs_pkg::*;

  logic [3*ByteW-1:0] recent_q, recent_d;
  logic [1:0]         pos_q, pos_d;
  logic               vowel_q, vowel_d;

  qfs_op_e op;
  logic    wend;
  logic    vowel_now;
  logic    byte_vowel;

  assign op   = qfs_op_e'(operation_i);
  assign wend = word_end_i | passage_end_i;

  // Vowel test on the incoming byte.
  assign byte_vowel = (text_byte_i == ChLowA) || (text_byte_i == ChLowE) ||
                      (text_byte_i == ChLowI) || (text_byte_i == ChLowO) ||
                      (text_byte_i == ChLowU) || (text_byte_i == ChUpA)  ||
                      (text_byte_i == ChUpE)  || (text_byte_i == ChUpI)  ||
                      (text_byte_i == ChUpO)  || (text_byte_i == ChUpU);
  assign vowel_now = vowel_q | byte_vowel;

  // Build the item and the next word state.
  always_comb begin
    item_o    = '0;
    recent_d  = recent_q;
    pos_d     = pos_q;
    vowel_d   = vowel_q;
    unique case (op)
      OP_LOAD: begin
        item_o.vld   = 1'b1;
        item_o.load  = 1'b1;
        item_o.index = table_index_i;
        item_o.keep  = table_keep_i;
        item_o.data  = table_gram_i;
      end
      OP_TEXT: begin
        item_o.vld     = 1'b1;
        item_o.data    = {recent_q, text_byte_i};
        item_o.chk     = (pos_q == 2'd3) && (recent_q[3*ByteW-1 -: ByteW] != ChUnmapped);
        item_o.unm_inc = (text_byte_i == ChUnmapped) && !wend;
        item_o.vwl_inc = wend && !vowel_now;
        item_o.emit    = passage_end_i;
        if (wend) begin
          recent_d = '0;
          pos_d    = '0;
          vowel_d  = 1'b0;
        end else begin
          recent_d = {recent_q[2*ByteW-1:0], text_byte_i};
          pos_d    = (pos_q == 2'd3) ? pos_q : pos_q + 2'd1;
          vowel_d  = vowel_now;
        end
      end
      OP_EMPTY: begin
        item_o.vld     = 1'b1;
        item_o.vwl_inc = 1'b1;
        item_o.emit    = passage_end_i;
        if (passage_end_i) begin
          recent_d = '0;
          pos_d    = '0;
          vowel_d  = 1'b0;
        end
      end
      OP_NONE: begin
        item_o = '0;
      end
    endcase
    if (!take_i) begin
      item_o.vld = 1'b0;
    end
  end

  // Word state advances only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      pos_q    <= '0;
      vowel_q  <= 1'b0;
    end else if (take_i) begin
      recent_q <= recent_d;
      pos_q    <= pos_d;
      vowel_q  <= vowel_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qfs_match_cell.sv =====
// ----------------------------------------------------------------------------
// qfs_match_cell
// One table slot of the cell row. It holds one gram, takes loads for its
// slot as they pass, and ORs its own match into a passing window's hit.
// ----------------------------------------------------------------------------
`default_nettype none

module qfs_match_cell #(
  parameter int unsigned CELL_ID = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  qfs_pkg::qfs_item_t item_i,
  output qfs_pkg::qfs_item_t item_o
);
  import qfs_pkg::*;

  qfs_item_t        item_q;
  logic [GramW-1:0] gram_q;
  logic             gram_vld_q;
  logic             slot_load;

  assign slot_load = item_q.vld && item_q.load &&
                     (32'(item_q.index) == 32'(CELL_ID));

  // Hand the item on with this cell's match folded in.
  always_comb begin
    item_o     = item_q;
    item_o.hit = item_q.hit |
                 (!item_q.load && gram_vld_q && (gram_q == item_q.data));
  end

  // Item stage of the row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_i;
    end
  end

  // Slot valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gram_vld_q <= 1'b0;
    end else if (en_i && slot_load) begin
      gram_vld_q <= item_q.keep;
    end
  end

  // Slot gram, read only while valid.
  always_ff @(posedge clk_i) begin
    if (en_i && slot_load) begin
      gram_q <= item_q.data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qfs_tally.sv =====
// ----------------------------------------------------------------------------
// qfs_tally
// Saturating passage counters at the end of the cell row, the fitness sum
// and the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module qfs_tally #(
  parameter int unsigned COUNT_BITS = qfs_pkg::CountBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qfs_pkg::qfs_item_t tail_i,
  output logic               adv_o,
  qfs_out_if.source          out_o
);
  import qfs_pkg::*;

  logic [COUNT_BITS-1:0] quad_q, vwl_q, unm_q;
  logic [COUNT_BITS-1:0] quad_d, vwl_d, unm_d;
  logic                  out_vld_q;
  logic                  take;
  logic [FitW-1:0]       q20, v20, u20, fit;

  function automatic logic [COUNT_BITS-1:0] sat_inc(
    input logic [COUNT_BITS-1:0] c,
    input logic                  inc
  );
    logic [COUNT_BITS-1:0] r;
    r = c;
    if (inc && (c != '1)) begin
      r = c + COUNT_BITS'(1);
    end
    return r;
  endfunction

  // The row stalls only when a result reaches a full, stalled output.
  assign adv_o = !(tail_i.vld && tail_i.emit && out_vld_q && !out_o.ready);
  assign take  = adv_o && tail_i.vld;

  // Counter updates for the item at the end of the row.
  assign quad_d = sat_inc(quad_q, tail_i.chk && tail_i.hit);
  assign vwl_d  = sat_inc(vwl_q, tail_i.vwl_inc);
  assign unm_d  = sat_inc(unm_q, tail_i.unm_inc);

  // Fitness kept to its field width.
  assign q20 = FitW'(quad_d);
  assign v20 = FitW'(vwl_d);
  assign u20 = FitW'(unm_d);
  assign fit = (q20 << 2) - (v20 << 2) - (u20 + (u20 << 1));

  // Counters clear when the closing item loads the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_q <= '0;
      vwl_q  <= '0;
      unm_q  <= '0;
    end else if (take) begin
      if (tail_i.emit) begin
        quad_q <= '0;
        vwl_q  <= '0;
        unm_q  <= '0;
      end else begin
        quad_q <= quad_d;
        vwl_q  <= vwl_d;
        unm_q  <= unm_d;
      end
    end
  end

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take && tail_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (take && tail_i.emit) begin
      out_o.fitness         <= signed'(fit);
      out_o.quad_hits       <= OutCntW'(quad_d);
      out_o.vowelless_words <= OutCntW'(vwl_d);
      out_o.unmapped_bytes  <= OutCntW'(unm_d);
    end
  end

  assign out_o.valid = out_vld_q;

endmodule

`default_nettype wire
